[hdl/fsat_pkg.sv]
// ----------------------------------------------------------------------------
// Format string argument typer package
// Item types, parser state types and the parser reset state.
// ----------------------------------------------------------------------------
package fsat_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       has_argument;
    logic [6:0] arg_position;
    logic [2:0] arg_type;
    logic       last_result;
  } out_item_t;

  typedef enum logic [6:0] {
    LX_OUT     = 7'b0000001,
    LX_QUOTE   = 7'b0000010,
    LX_PCT     = 7'b0000100,
    LX_LEN_H   = 7'b0001000,
    LX_LEN_L   = 7'b0010000,
    LX_LEN_ONE = 7'b0100000,
    LX_LEN_TWO = 7'b1000000
  } lx_e;

  typedef enum logic [15:0] {
    PS_LIT      = 16'h0001,
    PS_PCT      = 16'h0002,
    PS_POS      = 16'h0004,
    PS_FLAGS    = 16'h0008,
    PS_WDIG     = 16'h0010,
    PS_WSTAR    = 16'h0020,
    PS_WSTAR_D  = 16'h0040,
    PS_AFTER_W  = 16'h0080,
    PS_PREC     = 16'h0100,
    PS_PDIG     = 16'h0200,
    PS_PSTAR    = 16'h0400,
    PS_PSTAR_D  = 16'h0800,
    PS_LENGTH   = 16'h1000,
    PS_LEN_H    = 16'h2000,
    PS_LEN_L    = 16'h4000,
    PS_LEN_DONE = 16'h8000
  } ps_e;

  typedef enum logic [2:0] {
    LC_NONE = 3'd0,
    LC_HH   = 3'd1,
    LC_H    = 3'd2,
    LC_L    = 3'd3,
    LC_LL   = 3'd4,
    LC_WIDE = 3'd5,
    LC_BIGL = 3'd6
  } lc_e;

  typedef enum logic [1:0] {
    MODE_PRINTF = 2'd0,
    MODE_NS     = 2'd1,
    MODE_PRED   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef struct packed {
    lx_e        lx;
    logic [1:0] qk;
    ps_e        ps;
    logic [6:0] acc;
    logic       az;
    logic [6:0] spos;
    lc_e        lc;
    logic [6:0] seq;
    logic [1:0] nf;
    logic       rej;
  } ctx_t;

  typedef struct packed {
    logic       en;
    logic [6:0] pos;
    logic [2:0] typ;
  } add_t;

  typedef struct packed {
    ctx_t ctx;
    add_t a0;
    add_t a1;
  } step_t;

  localparam ctx_t CtxReset = '{lx: LX_OUT, qk: 2'd0, ps: PS_LIT, acc: 7'd0, az: 1'b1,
                                spos: 7'd0, lc: LC_NONE, seq: 7'd0, nf: 2'd0, rej: 1'b0};

endpackage

[hdl/fsat_parse.sv]
// ----------------------------------------------------------------------------
// Format string unit parser
// Lexes and parses one code unit against the current parser state and gives
// the next state together with up to two argument records for the type table.
// ----------------------------------------------------------------------------
module fsat_parse #(
  parameter int MAX_POSITIONS = 64
) (
  input  fsat_pkg::ctx_t     ctx_i,
  input  fsat_pkg::in_item_t item_i,
  input  logic [1:0]         mode_i,
  input  logic               pre_rej_i,
  output fsat_pkg::step_t    step_o
);

  localparam logic [6:0] MaxPos = 7'(MAX_POSITIONS);

  function automatic logic eq(logic [15:0] ch, logic [7:0] c);
    return ch == {8'h00, c};
  endfunction

  function automatic logic is_dig(logic [15:0] ch);
    return ch >= 16'h0030 && ch <= 16'h0039;
  endfunction

  function automatic fsat_pkg::step_t add_fn(fsat_pkg::step_t s, logic [6:0] pos,
                                             logic [2:0] typ);
    logic [6:0] p;
    p = pos;
    s.ctx.nf = s.ctx.nf | ((pos != 7'd0) ? 2'b01 : 2'b10);
    if (s.ctx.nf == 2'b11) begin
      s.ctx.rej = 1'b1;
    end else begin
      if (pos == 7'd0) begin
        if (s.ctx.seq >= MaxPos) begin
          s.ctx.rej = 1'b1;
        end else begin
          s.ctx.seq = s.ctx.seq + 7'd1;
          p = s.ctx.seq;
        end
      end
      if (!s.ctx.rej) begin
        if (p == 7'd0 || p > MaxPos) begin
          s.ctx.rej = 1'b1;
        end else if (!s.a0.en) begin
          s.a0 = '{en: 1'b1, pos: p, typ: typ};
        end else begin
          s.a1 = '{en: 1'b1, pos: p, typ: typ};
        end
      end
    end
    return s;
  endfunction

  function automatic fsat_pkg::ctx_t dig_fn(fsat_pkg::ctx_t c, logic [15:0] ch);
    logic [9:0] v;
    v = 10'(c.acc) * 10'd10 + 10'(ch[3:0]);
    if (ch[3:0] != 4'd0) begin
      c.az = 1'b0;
    end
    c.acc = (v > 10'(MaxPos) + 10'd1) ? MaxPos + 7'd1 : v[6:0];
    return c;
  endfunction

  function automatic fsat_pkg::step_t conv_fn(fsat_pkg::step_t s, logic [15:0] ch, logic ns);
    fsat_pkg::lc_e lc;
    logic          bad;
    logic          narrow;
    logic          sgn;
    logic [2:0]    t;
    lc = s.ctx.lc;
    s.ctx.ps = fsat_pkg::PS_LIT;
    s.ctx.lc = fsat_pkg::LC_NONE;
    bad = 1'b0;
    t = 3'd0;
    narrow = lc == fsat_pkg::LC_NONE || lc == fsat_pkg::LC_H || lc == fsat_pkg::LC_HH;
    sgn = eq(ch, "d") || eq(ch, "i") || lc == fsat_pkg::LC_H || lc == fsat_pkg::LC_HH;
    if (eq(ch, "d") || eq(ch, "i") || eq(ch, "o") || eq(ch, "u") || eq(ch, "x") ||
        eq(ch, "X")) begin
      bad = lc == fsat_pkg::LC_BIGL;
      t = {1'b0, !narrow, !sgn};
    end else if (eq(ch, "a") || eq(ch, "A") || eq(ch, "e") || eq(ch, "E") ||
                 eq(ch, "f") || eq(ch, "F") || eq(ch, "g") || eq(ch, "G")) begin
      bad = lc != fsat_pkg::LC_NONE && lc != fsat_pkg::LC_L;
      t = 3'd4;
    end else begin
      if (eq(ch, "c") || (ns && eq(ch, "C"))) begin
        t = 3'd0;
      end else if (eq(ch, "s")) begin
        t = 3'd5;
      end else if (ns && eq(ch, "S")) begin
        t = 3'd6;
      end else if (eq(ch, "p") || (ns && eq(ch, "@"))) begin
        t = 3'd7;
      end else begin
        bad = 1'b1;
      end
      if (lc != fsat_pkg::LC_NONE) begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      s.ctx.rej = 1'b1;
    end else begin
      s = add_fn(s, s.ctx.spos, t);
    end
    return s;
  endfunction

  function automatic fsat_pkg::step_t parse_fn(fsat_pkg::step_t s, logic [15:0] ch,
                                               logic ns);
    logic          go;
    logic          wid;
    logic          seen;
    fsat_pkg::ps_e nxt;
    go = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (go && !s.ctx.rej) begin
        wid = s.ctx.ps == fsat_pkg::PS_WSTAR || s.ctx.ps == fsat_pkg::PS_WSTAR_D;
        seen = s.ctx.ps == fsat_pkg::PS_WSTAR_D || s.ctx.ps == fsat_pkg::PS_PSTAR_D;
        nxt = wid ? fsat_pkg::PS_AFTER_W : fsat_pkg::PS_LENGTH;
        unique case (s.ctx.ps)
          fsat_pkg::PS_LIT: begin
            if (eq(ch, "%")) s.ctx.ps = fsat_pkg::PS_PCT;
            go = 1'b0;
          end
          fsat_pkg::PS_PCT: begin
            if (eq(ch, "%")) begin
              s.ctx.ps = fsat_pkg::PS_LIT;
              go = 1'b0;
            end else begin
              s.ctx.acc = 7'd0;
              s.ctx.az = 1'b1;
              s.ctx.ps = fsat_pkg::PS_POS;
            end
          end
          fsat_pkg::PS_POS: begin
            if (is_dig(ch)) begin
              s.ctx = dig_fn(s.ctx, ch);
              go = 1'b0;
            end else if (eq(ch, "$")) begin
              if (s.ctx.az || s.ctx.acc > MaxPos) begin
                s.ctx.rej = 1'b1;
              end else begin
                s.ctx.spos = s.ctx.acc;
                s.ctx.ps = fsat_pkg::PS_FLAGS;
              end
              go = 1'b0;
            end else begin
              s.ctx.spos = 7'd0;
              s.ctx.ps = s.ctx.az ? fsat_pkg::PS_FLAGS : fsat_pkg::PS_AFTER_W;
            end
          end
          fsat_pkg::PS_FLAGS: begin
            if (eq(ch, "-") || eq(ch, "+") || eq(ch, " ") || eq(ch, "#") ||
                eq(ch, "0") || eq(ch, 8'h27)) begin
              go = 1'b0;
            end else if (eq(ch, "*")) begin
              s.ctx.acc = 7'd0;
              s.ctx.az = 1'b1;
              s.ctx.ps = fsat_pkg::PS_WSTAR;
              go = 1'b0;
            end else if (is_dig(ch)) begin
              s.ctx.ps = fsat_pkg::PS_WDIG;
              go = 1'b0;
            end else begin
              s.ctx.ps = fsat_pkg::PS_AFTER_W;
            end
          end
          fsat_pkg::PS_PREC: begin
            if (eq(ch, "*")) begin
              s.ctx.acc = 7'd0;
              s.ctx.az = 1'b1;
              s.ctx.ps = fsat_pkg::PS_PSTAR;
              go = 1'b0;
            end else if (is_dig(ch)) begin
              s.ctx.ps = fsat_pkg::PS_PDIG;
              go = 1'b0;
            end else begin
              s.ctx.ps = fsat_pkg::PS_LENGTH;
            end
          end
          fsat_pkg::PS_WDIG, fsat_pkg::PS_PDIG: begin
            if (is_dig(ch)) begin
              go = 1'b0;
            end else begin
              s.ctx.ps = (s.ctx.ps == fsat_pkg::PS_WDIG) ? fsat_pkg::PS_AFTER_W
                                                         : fsat_pkg::PS_LENGTH;
            end
          end
          fsat_pkg::PS_WSTAR, fsat_pkg::PS_WSTAR_D,
          fsat_pkg::PS_PSTAR, fsat_pkg::PS_PSTAR_D: begin
            if (is_dig(ch)) begin
              s.ctx = dig_fn(s.ctx, ch);
              s.ctx.ps = wid ? fsat_pkg::PS_WSTAR_D : fsat_pkg::PS_PSTAR_D;
              go = 1'b0;
            end else if (eq(ch, "$")) begin
              if (s.ctx.az || s.ctx.acc > MaxPos) begin
                s.ctx.rej = 1'b1;
              end else begin
                s = add_fn(s, s.ctx.acc, 3'd0);
                s.ctx.ps = nxt;
              end
              go = 1'b0;
            end else if (seen) begin
              s.ctx.rej = 1'b1;
              go = 1'b0;
            end else begin
              s = add_fn(s, 7'd0, 3'd0);
              s.ctx.ps = nxt;
            end
          end
          fsat_pkg::PS_AFTER_W: begin
            if (eq(ch, ".")) begin
              s.ctx.ps = fsat_pkg::PS_PREC;
              go = 1'b0;
            end else begin
              s.ctx.ps = fsat_pkg::PS_LENGTH;
            end
          end
          fsat_pkg::PS_LENGTH: begin
            if (eq(ch, "h")) begin
              s.ctx.lc = fsat_pkg::LC_H;
              s.ctx.ps = fsat_pkg::PS_LEN_H;
            end else if (eq(ch, "l")) begin
              s.ctx.lc = fsat_pkg::LC_L;
              s.ctx.ps = fsat_pkg::PS_LEN_L;
            end else if (eq(ch, "q") || eq(ch, "j") || eq(ch, "z") || eq(ch, "t")) begin
              s.ctx.lc = fsat_pkg::LC_WIDE;
              s.ctx.ps = fsat_pkg::PS_LEN_DONE;
            end else if (eq(ch, "L")) begin
              s.ctx.lc = fsat_pkg::LC_BIGL;
              s.ctx.ps = fsat_pkg::PS_LEN_DONE;
            end else begin
              s = conv_fn(s, ch, ns);
            end
            go = 1'b0;
          end
          fsat_pkg::PS_LEN_H: begin
            if (eq(ch, "h")) begin
              s.ctx.lc = fsat_pkg::LC_HH;
              s.ctx.ps = fsat_pkg::PS_LEN_DONE;
            end else begin
              s = conv_fn(s, ch, ns);
            end
            go = 1'b0;
          end
          fsat_pkg::PS_LEN_L: begin
            if (eq(ch, "l")) begin
              s.ctx.lc = fsat_pkg::LC_LL;
              s.ctx.ps = fsat_pkg::PS_LEN_DONE;
            end else begin
              s = conv_fn(s, ch, ns);
            end
            go = 1'b0;
          end
          fsat_pkg::PS_LEN_DONE: begin
            s = conv_fn(s, ch, ns);
            go = 1'b0;
          end
          default: go = 1'b0;
        endcase
      end
    end
    return s;
  endfunction

  function automatic fsat_pkg::step_t lex_fn(fsat_pkg::step_t s, logic [15:0] ch);
    logic          call;
    logic          fall;
    logic [15:0]   pc;
    fsat_pkg::lx_e nlx;
    call = 1'b0;
    fall = 1'b0;
    pc = ch;
    nlx = s.ctx.lx;
    if (eq(ch, 8'h5C)) begin
      s.ctx.rej = 1'b1;
    end else begin
      unique case (s.ctx.lx)
        fsat_pkg::LX_OUT: begin
          if (eq(ch, 8'h27) || eq(ch, 8'h22)) begin
            s.ctx.qk = eq(ch, 8'h27) ? 2'd1 : 2'd2;
            nlx = fsat_pkg::LX_QUOTE;
          end else if (eq(ch, "%")) begin
            call = 1'b1;
            nlx = fsat_pkg::LX_PCT;
          end
        end
        fsat_pkg::LX_QUOTE: begin
          if ((s.ctx.qk == 2'd1 && eq(ch, 8'h27)) || (s.ctx.qk == 2'd2 && eq(ch, 8'h22))) begin
            s.ctx.qk = 2'd0;
            nlx = fsat_pkg::LX_OUT;
          end
        end
        fsat_pkg::LX_PCT: begin
          if (eq(ch, "K") || eq(ch, "@")) begin
            call = 1'b1;
            pc = {8'h00, 8'h40};
            nlx = fsat_pkg::LX_OUT;
          end else if (eq(ch, "h") || eq(ch, "l") || eq(ch, "q") || eq(ch, "j") ||
                       eq(ch, "z") || eq(ch, "t")) begin
            call = 1'b1;
            nlx = eq(ch, "h") ? fsat_pkg::LX_LEN_H :
                  eq(ch, "l") ? fsat_pkg::LX_LEN_L : fsat_pkg::LX_LEN_ONE;
          end else begin
            fall = 1'b1;
          end
        end
        fsat_pkg::LX_LEN_H, fsat_pkg::LX_LEN_L: begin
          if ((s.ctx.lx == fsat_pkg::LX_LEN_H && eq(ch, "h")) ||
              (s.ctx.lx == fsat_pkg::LX_LEN_L && eq(ch, "l"))) begin
            call = 1'b1;
            nlx = fsat_pkg::LX_LEN_TWO;
          end else begin
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase
      if (fall) begin
        if (eq(ch, "d") || eq(ch, "i") || eq(ch, "o") || eq(ch, "u") || eq(ch, "x") ||
            eq(ch, "X") || eq(ch, "a") || eq(ch, "A") || eq(ch, "e") || eq(ch, "E") ||
            eq(ch, "f") || eq(ch, "F") || eq(ch, "g") || eq(ch, "G")) begin
          call = 1'b1;
          nlx = fsat_pkg::LX_OUT;
        end else begin
          s.ctx.rej = 1'b1;
        end
      end
      if (call) begin
        s = parse_fn(s, pc, 1'b1);
      end
      s.ctx.lx = nlx;
    end
    return s;
  endfunction

  always_comb begin
    step_o = '0;
    step_o.ctx = ctx_i;
    step_o.ctx.rej = ctx_i.rej | pre_rej_i;
    if (!step_o.ctx.rej) begin
      if (mode_i == fsat_pkg::MODE_PRED) begin
        step_o = lex_fn(step_o, item_i.code_unit);
      end else begin
        step_o = parse_fn(step_o, item_i.code_unit, mode_i == fsat_pkg::MODE_NS);
      end
    end
    if (item_i.last_unit) begin
      if ((mode_i == fsat_pkg::MODE_PRED && step_o.ctx.lx != fsat_pkg::LX_OUT) ||
          step_o.ctx.ps != fsat_pkg::PS_LIT) begin
        step_o.ctx.rej = 1'b1;
      end
    end
  end

endmodule

[hdl/format_string_argument_typer_top.sv]
// ----------------------------------------------------------------------------
// Format string argument typer
// Parses a format string one code unit per item and, at the last unit, gives
// the argument type list in position order or, if rejected or empty, one item.
// ----------------------------------------------------------------------------
//  Channel  | Signals                              | Item
//  in       | in_valid_i / in_ready_o / in_item_i  | code unit and last mark
//  out      | out_valid_o / out_ready_i / out_item_o | status and argument type
//  cfg      | cfg_we_i / cfg_wdata_i               | syntax mode
//
// Each argument that a unit records in the type table (at most two per unit)
// passes a read state and then a write state of the single-port table, and no
// new unit is taken meanwhile. At the last unit a final state decides the
// outcome, and each argument result then passes a read and a load state.
// Reset clears the state at once; the table needs no clearing pass as its
// valid bits are flip-flops. A stalled output holds the walk in place.
module format_string_argument_typer_top #(
  parameter int MAX_POSITIONS = 64,
  parameter int MAX_UNITS     = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fsat_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fsat_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);

  localparam int AW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int UCW = $clog2(MAX_UNITS + 2);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ARD  = 6'b000010,
    ST_AWR  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_ERD  = 6'b010000,
    ST_ELD  = 6'b100000
  } st_e;

  st_e                    state_q, state_d;
  logic [1:0]             mode_q, mode_d;
  fsat_pkg::ctx_t         ctx_q, ctx_d;
  logic [UCW-1:0]         ucnt_q, ucnt_d, ucnt_nx;
  fsat_pkg::add_t         add0_q, add0_d, add1_q, add1_d, cur;
  logic                   sel_q, sel_d, last_q, last_d;
  logic [MAX_POSITIONS-1:0] valid_q, valid_d;
  logic [AW-1:0]          ptr_q, ptr_d, addr_cur, rd_addr;
  logic [AW:0]            nxt;
  fsat_pkg::out_item_t    out_q, out_d;
  logic                   ovld_q, ovld_d;
  logic [2:0]             mem [MAX_POSITIONS];
  logic [2:0]             rd_q;
  logic                   we, pre_rej, gap, out_free, lastr;
  fsat_pkg::step_t        step;

  assign ucnt_nx = (ucnt_q <= UCW'(MAX_UNITS)) ? ucnt_q + UCW'(1) : ucnt_q;
  assign pre_rej = (ucnt_nx > UCW'(MAX_UNITS)) || (mode_q == fsat_pkg::MODE_NONE) ||
                   (in_item_i.code_unit == 16'd0);

  fsat_parse #(.MAX_POSITIONS(MAX_POSITIONS)) u_parse (
    .ctx_i    (ctx_q),
    .item_i   (in_item_i),
    .mode_i   (mode_q),
    .pre_rej_i(pre_rej),
    .step_o   (step)
  );

  assign cur      = sel_q ? add1_q : add0_q;
  assign addr_cur = AW'(cur.pos - 7'd1);
  assign rd_addr  = (state_q == ST_ERD) ? ptr_q : addr_cur;
  assign nxt      = {1'b0, ptr_q} + (AW + 1)'(1);
  assign lastr    = (nxt == (AW + 1)'(MAX_POSITIONS)) || !valid_q[nxt[AW-1:0]];
  assign out_free = !ovld_q || out_ready_i;

  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < MAX_POSITIONS - 1; i++) begin
      gap = gap | (!valid_q[i] && valid_q[i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_cur] <= cur.typ;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    mode_d  = cfg_we_i ? cfg_wdata_i : mode_q;
    ctx_d   = ctx_q;
    ucnt_d  = ucnt_q;
    add0_d  = add0_q;
    add1_d  = add1_q;
    sel_d   = sel_q;
    last_d  = last_q;
    valid_d = valid_q;
    ptr_d   = ptr_q;
    out_d   = out_q;
    ovld_d  = ovld_q && !out_ready_i;
    we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctx_d   = step.ctx;
          ucnt_d  = ucnt_nx;
          add0_d  = step.a0;
          add1_d  = step.a1;
          sel_d   = 1'b0;
          last_d  = in_item_i.last_unit;
          state_d = step.a0.en ? ST_ARD : (in_item_i.last_unit ? ST_FIN : ST_IDLE);
        end
      end
      ST_ARD: state_d = ST_AWR;
      ST_AWR: begin
        if (valid_q[addr_cur]) begin
          if (rd_q != cur.typ) ctx_d.rej = 1'b1;
        end else begin
          we = 1'b1;
          valid_d[addr_cur] = 1'b1;
        end
        if (!sel_q && add1_q.en) begin
          sel_d   = 1'b1;
          state_d = ST_ARD;
        end else begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (ctx_q.rej || gap || !valid_q[0]) begin
            out_d   = '{status: ctx_q.rej | gap, has_argument: 1'b0, arg_position: 7'd0,
                        arg_type: 3'd0, last_result: 1'b1};
            ovld_d  = 1'b1;
            ctx_d   = fsat_pkg::CtxReset;
            ucnt_d  = '0;
            valid_d = '0;
            state_d = ST_IDLE;
          end else begin
            ptr_d   = '0;
            state_d = ST_ERD;
          end
        end
      end
      ST_ERD: begin
        if (out_free) state_d = ST_ELD;
      end
      ST_ELD: begin
        out_d  = '{status: 1'b0, has_argument: 1'b1, arg_position: 7'(nxt),
                   arg_type: rd_q, last_result: lastr};
        ovld_d = 1'b1;
        if (lastr) begin
          ctx_d   = fsat_pkg::CtxReset;
          ucnt_d  = '0;
          valid_d = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d   = nxt[AW-1:0];
          state_d = ST_ERD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= fsat_pkg::MODE_NS;
      ctx_q   <= fsat_pkg::CtxReset;
      ucnt_q  <= '0;
      add0_q  <= '0;
      add1_q  <= '0;
      sel_q   <= 1'b0;
      last_q  <= 1'b0;
      valid_q <= '0;
      ptr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      ctx_q   <= ctx_d;
      ucnt_q  <= ucnt_d;
      add0_q  <= add0_d;
      add1_q  <= add1_d;
      sel_q   <= sel_d;
      last_q  <= last_d;
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = ovld_q;
  assign out_item_o  = out_q;

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AWR |-> $past(state_q) == ST_ARD)
    else $error("table write without a preceding read");

  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |-> out_item_o.last_result && !out_item_o.has_argument)
    else $error("rejection item is not a lone final item");

  a_arg_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.has_argument |-> out_item_o.arg_position != 7'd0)
    else $error("argument item without a position");

endmodule

[tb/sv/fsat_checker.sv]
// ----------------------------------------------------------------------------
// Format string argument typer checker
// Watches both channels, types each accepted format string with its own
// parser model and compares every result item with the oldest expectation.
// ----------------------------------------------------------------------------
module fsat_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  fsat_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  fsat_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_seen_o
);

  localparam int MaxPos   = 64;
  localparam int MaxUnits = 65536;

  typedef enum int {
    LEX_OUT, LEX_QUOTE, LEX_PCT, LEX_LEN_H, LEX_LEN_L, LEX_LEN_ONE, LEX_LEN_TWO
  } lex_e;
  typedef enum int {
    P_LIT, P_PCT, P_POS, P_FLAGS, P_WDIG, P_WSTAR, P_WSTAR_D, P_AFTER_W,
    P_PREC, P_PDIG, P_PSTAR, P_PSTAR_D, P_LENGTH, P_LEN_H, P_LEN_L, P_LEN_DONE
  } pst_e;

  fsat_pkg::mode_e     mode;
  lex_e                lex;
  int                  quote;
  pst_e                pst;
  int                  acc;
  bit                  all_zero;
  int                  spec_pos;
  fsat_pkg::lc_e       len;
  int                  seq_count;
  bit [1:0]            numbering;
  int                  units;
  bit                  rejected;
  bit                  slot_used [MaxPos];
  bit [2:0]            slot_type [MaxPos];
  fsat_pkg::out_item_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic bit in_str(int c, string s);
    if (c == 0 || c > 127) return 0;
    foreach (s[i]) if (s[i] == c) return 1;
    return 0;
  endfunction

  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_string();
    lex = LEX_OUT; quote = 0; pst = P_LIT; acc = 0; all_zero = 1; spec_pos = 0;
    len = fsat_pkg::LC_NONE; seq_count = 0; numbering = 0; units = 0; rejected = 0;
    foreach (slot_used[i]) begin
      slot_used[i] = 0;
      slot_type[i] = 0;
    end
  endfunction

  function automatic void take_digit(int c);
    int v;
    v = acc * 10 + (c - "0");
    if (c != "0") all_zero = 0;
    acc = v > MaxPos + 1 ? MaxPos + 1 : v;
  endfunction

  function automatic bit pos_valid();
    return !all_zero && acc <= MaxPos;
  endfunction

  function automatic void record_arg(int pos, int typ);
    numbering |= (pos != 0) ? 2'b01 : 2'b10;
    if (numbering == 2'b11) begin
      rejected = 1;
      return;
    end
    if (pos == 0) begin
      if (seq_count >= MaxPos) begin
        rejected = 1;
        return;
      end
      seq_count++;
      pos = seq_count;
    end
    if (pos < 1 || pos > MaxPos) begin
      rejected = 1;
      return;
    end
    if (!slot_used[pos-1]) begin
      slot_used[pos-1] = 1;
      slot_type[pos-1] = 3'(typ);
    end else if (slot_type[pos-1] != typ) begin
      rejected = 1;
    end
  endfunction

  function automatic void convert(int c, bit ns);
    fsat_pkg::lc_e lc;
    int            t;
    bit            narrow, sgn;
    lc = len;
    pst = P_LIT;
    len = fsat_pkg::LC_NONE;
    if (in_str(c, "diouxX")) begin
      narrow = lc == fsat_pkg::LC_NONE || lc == fsat_pkg::LC_H || lc == fsat_pkg::LC_HH;
      sgn = c == "d" || c == "i" || lc == fsat_pkg::LC_H || lc == fsat_pkg::LC_HH;
      if (lc == fsat_pkg::LC_BIGL) begin
        rejected = 1;
        return;
      end
      t = (narrow ? 0 : 2) + (sgn ? 0 : 1);
    end else if (in_str(c, "aAeEfFgG")) begin
      if (lc != fsat_pkg::LC_NONE && lc != fsat_pkg::LC_L) begin
        rejected = 1;
        return;
      end
      t = 4;
    end else begin
      if (c == "c" || (ns && c == "C")) t = 0;
      else if (c == "s") t = 5;
      else if (ns && c == "S") t = 6;
      else if (c == "p" || (ns && c == "@")) t = 7;
      else begin
        rejected = 1;
        return;
      end
      if (lc != fsat_pkg::LC_NONE) begin
        rejected = 1;
        return;
      end
    end
    record_arg(spec_pos, t);
  endfunction

  function automatic void parse(int c, bit ns);
    bit wid, seen;
    pst_e nxt;
    for (int step = 0; step < 12 && !rejected; step++) begin
      case (pst)
        P_LIT: begin
          if (c == "%") pst = P_PCT;
          return;
        end
        P_PCT: begin
          if (c == "%") begin
            pst = P_LIT;
            return;
          end
          acc = 0; all_zero = 1; pst = P_POS;
        end
        P_POS: begin
          if (is_dig(c)) begin
            take_digit(c);
            return;
          end
          if (c == "$") begin
            if (!pos_valid()) begin
              rejected = 1;
              return;
            end
            spec_pos = acc; pst = P_FLAGS;
            return;
          end
          spec_pos = 0;
          pst = all_zero ? P_FLAGS : P_AFTER_W;
        end
        P_FLAGS: begin
          if (in_str(c, "-+ #0'")) return;
          if (c == "*") begin
            acc = 0; all_zero = 1; pst = P_WSTAR;
            return;
          end
          if (is_dig(c)) begin
            pst = P_WDIG;
            return;
          end
          pst = P_AFTER_W;
        end
        P_PREC: begin
          if (c == "*") begin
            acc = 0; all_zero = 1; pst = P_PSTAR;
            return;
          end
          if (is_dig(c)) begin
            pst = P_PDIG;
            return;
          end
          pst = P_LENGTH;
        end
        P_WDIG, P_PDIG: begin
          if (is_dig(c)) return;
          pst = (pst == P_WDIG) ? P_AFTER_W : P_LENGTH;
        end
        P_WSTAR, P_WSTAR_D, P_PSTAR, P_PSTAR_D: begin
          wid = pst == P_WSTAR || pst == P_WSTAR_D;
          seen = pst == P_WSTAR_D || pst == P_PSTAR_D;
          nxt = wid ? P_AFTER_W : P_LENGTH;
          if (is_dig(c)) begin
            take_digit(c);
            pst = wid ? P_WSTAR_D : P_PSTAR_D;
            return;
          end
          if (c == "$") begin
            if (!pos_valid()) begin
              rejected = 1;
              return;
            end
            record_arg(acc, 0);
            pst = nxt;
            return;
          end
          if (seen) begin
            rejected = 1;
            return;
          end
          record_arg(0, 0);
          pst = nxt;
        end
        P_AFTER_W: begin
          if (c == ".") begin
            pst = P_PREC;
            return;
          end
          pst = P_LENGTH;
        end
        P_LENGTH: begin
          if (c == "h") begin
            len = fsat_pkg::LC_H; pst = P_LEN_H;
          end else if (c == "l") begin
            len = fsat_pkg::LC_L; pst = P_LEN_L;
          end else if (c == "q" || c == "j" || c == "z" || c == "t") begin
            len = fsat_pkg::LC_WIDE; pst = P_LEN_DONE;
          end else if (c == "L") begin
            len = fsat_pkg::LC_BIGL; pst = P_LEN_DONE;
          end else begin
            convert(c, ns);
          end
          return;
        end
        P_LEN_H: begin
          if (c == "h") begin
            len = fsat_pkg::LC_HH; pst = P_LEN_DONE;
          end else begin
            convert(c, ns);
          end
          return;
        end
        P_LEN_L: begin
          if (c == "l") begin
            len = fsat_pkg::LC_LL; pst = P_LEN_DONE;
          end else begin
            convert(c, ns);
          end
          return;
        end
        default: begin
          convert(c, ns);
          return;
        end
      endcase
    end
  endfunction

  function automatic void lex_pred(int c);
    if (c == "\\") begin
      rejected = 1;
      return;
    end
    case (lex)
      LEX_OUT: begin
        if (c == "'" || c == "\"") begin
          quote = (c == "'") ? 1 : 2;
          lex = LEX_QUOTE;
        end else if (c == "%") begin
          parse("%", 1);
          lex = LEX_PCT;
        end
        return;
      end
      LEX_QUOTE: begin
        if ((quote == 1 && c == "'") || (quote == 2 && c == "\"")) begin
          quote = 0;
          lex = LEX_OUT;
        end
        return;
      end
      LEX_PCT: begin
        if (c == "K" || c == "@") begin
          parse("@", 1);
          lex = LEX_OUT;
          return;
        end
        if (in_str(c, "hlqjzt")) begin
          parse(c, 1);
          lex = (c == "h") ? LEX_LEN_H : (c == "l") ? LEX_LEN_L : LEX_LEN_ONE;
          return;
        end
      end
      LEX_LEN_H, LEX_LEN_L: begin
        if ((lex == LEX_LEN_H && c == "h") || (lex == LEX_LEN_L && c == "l")) begin
          parse(c, 1);
          lex = LEX_LEN_TWO;
          return;
        end
      end
      default: ;
    endcase
    if (!in_str(c, "diouxXaAeEfFgG")) begin
      rejected = 1;
      return;
    end
    parse(c, 1);
    lex = LEX_OUT;
  endfunction

  function automatic void type_unit(int c, bit last);
    int                  n;
    bit                  gap;
    fsat_pkg::out_item_t r;
    if (units <= MaxUnits) units++;
    if (units > MaxUnits || mode == fsat_pkg::MODE_NONE || c == 0) rejected = 1;
    if (!rejected) begin
      if (mode == fsat_pkg::MODE_PRED) lex_pred(c);
      else parse(c, mode == fsat_pkg::MODE_NS);
    end
    if (!last) return;
    if (mode == fsat_pkg::MODE_PRED && lex != LEX_OUT) rejected = 1;
    if (pst != P_LIT) rejected = 1;
    n = 0;
    gap = 0;
    for (int i = 0; i < MaxPos && !rejected; i++) begin
      if (slot_used[i]) begin
        if (gap) rejected = 1;
        else n++;
      end else begin
        gap = 1;
      end
    end
    if (rejected || n == 0) begin
      r = '0;
      r.status = rejected;
      r.last_result = 1'b1;
      expected_q.insert(expected_q.size(), r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.has_argument = 1'b1;
        r.arg_position = 7'(i + 1);
        r.arg_type = slot_type[i];
        r.last_result = (i == n - 1);
        expected_q.insert(expected_q.size(), r);
      end
    end
    clear_string();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fsat_pkg::out_item_t e;
    if (!rst_ni) begin
      mode <= fsat_pkg::MODE_NS;
      clear_string();
      expected_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item %p", $time, out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_item_i) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, e, out_item_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        type_unit(in_item_i.code_unit, in_item_i.last_unit);
      if (cfg_we_i) mode <= fsat_pkg::mode_e'(cfg_wdata_i);
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Format string argument typer testbench
// Sends directed and random format strings in every dialect under random
// gaps and output stalls; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb;

  localparam int Limit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  fsat_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  fsat_pkg::out_item_t out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_wdata_i = 2'd0;
  int                  fail_count, pending, results_seen;
  int                  cycles = 0;
  int                  strings_sent = 0;
  int                  units_sent = 0;
  bit                  hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  format_string_argument_typer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  fsat_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .in_item_i(in_item_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_item_i(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off) out_ready_i <= 1'b0;
    else if (cycles % 2000 < 600) out_ready_i <= 1'b1;
    else if (r < 70) out_ready_i <= 1'b1;
    else if (r < 97) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) == 0);
  end

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    return n;
  endfunction

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_unit(logic [15:0] c, logic last);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{code_unit: c, last_unit: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    units_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_unit(16'(s[i]), i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic set_mode(fsat_pkg::mode_e m);
    idle_input();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic string pick(string s);
    int k;
    k = $urandom_range(0, s.len() - 1);
    return s.substr(k, k);
  endfunction

  function automatic string rand_spec(bit pred);
    string s;
    int k;
    if (pred) begin
      k = $urandom_range(0, 9);
      if (k == 0) return "%K";
      if (k == 1) return "%@";
      if (k == 2) return "'a%d'";
      s = "%";
      if ($urandom_range(0, 2) == 0) s = {s, pick("hlqjzt")};
      return {s, pick("diouxXaAeEfFgG")};
    end
    s = "%";
    if ($urandom_range(0, 9) == 0) return "%%";
    if ($urandom_range(0, 5) == 0) s = {s, $sformatf("%0d$", $urandom_range(1, 4))};
    if ($urandom_range(0, 2) == 0) s = {s, pick("-+ #0'")};
    k = $urandom_range(0, 5);
    if (k == 0) s = {s, "12"};
    else if (k == 1) s = {s, "*"};
    if ($urandom_range(0, 3) == 0) s = {s, ".", pick("3*")};
    if ($urandom_range(0, 3) == 0) s = {s, pick("hlqjztL")};
    if ($urandom_range(0, 9) == 0) s = {s, "hh"};
    return {s, pick("diouxXaAeEfFgGcCsSp@")};
  endfunction

  task automatic random_strings(fsat_pkg::mode_e m, int count);
    string s;
    int k;
    for (int n = 0; n < count; n++) begin
      s = "";
      k = $urandom_range(0, 9);
      if (k < 7) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) s = {s, "ab"};
          s = {s, rand_spec(m == fsat_pkg::MODE_PRED)};
        end
        send_string(s);
      end else if (k < 9) begin
        repeat ($urandom_range(1, 5)) begin
          send_unit($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(32, 126)), 0);
        end
        send_unit($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(32, 126)), 1);
        strings_sent++;
      end else begin
        send_string({"%", pick("123"), "$d%d"});
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_string("hello");
    send_string("%d%u%lld%llu%f%s%p%@%C%S%hhx%c");
    send_string("%2$s%1$d%2$s");
    send_string("%*.*d%%");
    send_string("%1$d%3$d");
    send_string("%65$d");
    send_string("%0$d");
    send_string("%Ld");
    send_string("%12");
    send_string("%*5d");
    send_unit(16'h0000, 1); strings_sent++;
    send_unit(16'hFFFF, 0); send_unit(16'h8000, 0); send_unit(16'h5555, 1); strings_sent++;
    send_string("%64$d");
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_strings(fsat_pkg::MODE_NS, 3);
    join
    random_strings(fsat_pkg::MODE_NS, 1);
    set_mode(fsat_pkg::MODE_PRINTF);
    send_string("%@%C%S");
    random_strings(fsat_pkg::MODE_PRINTF, 2);
    set_mode(fsat_pkg::MODE_PRED);
    send_string("%K 'x\\' \"q%d\" %lld %@");
    send_string("'abc");
    send_string("%hhd%s");
    send_string("a\\b");
    random_strings(fsat_pkg::MODE_PRED, 1);
    set_mode(fsat_pkg::MODE_NONE);
    send_string("%d");
    set_mode(fsat_pkg::MODE_NS);
    random_strings(fsat_pkg::MODE_NS, 1);
    idle_input();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("sent %0d strings (%0d units) over all four modes, checked %0d results",
             strings_sent, units_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
